// ===== design/packed_max_register_file_top_defines.svh =====
// Assertion macros for the packed maximum register file.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef PACKED_MAX_REGISTER_FILE_TOP_DEFINES_SVH
`define PACKED_MAX_REGISTER_FILE_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define PMRF_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define PMRF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define PMRF_ASSERT(label, clk, rst, prop, msg)
`define PMRF_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

// ===== design/pmrf_pkg.sv =====
// Shared constants, operation codes and transaction types of the packed
// maximum register file. No dependencies.
package pmrf_pkg;

   localparam int NUM_REGISTERS = 1024;
   localparam int REG_BITS      = 5;
   localparam int REGS_PER_WORD = 6;
   localparam int WORD_BITS     = REG_BITS * REGS_PER_WORD;
   localparam int NUM_WORDS     = (NUM_REGISTERS + REGS_PER_WORD - 1) / REGS_PER_WORD;
   localparam int ADDR_BITS     = $clog2(NUM_WORDS);
   localparam int POS_BITS      = 10;
   localparam int WIDX_BITS     = 8;
   localparam int FUNC_BITS     = 3;
   localparam int SEL_BITS      = $clog2(REGS_PER_WORD);

   // floor(pos / 6) as (pos * 683) >> 12, exact over the full 10-bit position range
   localparam int DIV6_MULT     = 683;
   localparam int DIV6_SHIFT    = 12;
   localparam int PROD_BITS     = POS_BITS + 10;

   typedef enum logic [FUNC_BITS-1:0] {
      FUNC_READ_REG   = 3'd0,
      FUNC_WRITE_REG  = 3'd1,
      FUNC_UPDATE_MAX = 3'd2,
      FUNC_MERGE_WORD = 3'd3,
      FUNC_WRITE_WORD = 3'd4,
      FUNC_READ_WORD  = 3'd5
   } func_type;

   typedef struct packed {
      logic [FUNC_BITS-1:0] func;
      logic [POS_BITS-1:0]  position;
      logic [REG_BITS-1:0]  value;
      logic [WIDX_BITS-1:0] word_index;
      logic [WORD_BITS-1:0] word_data;
   } req_type;

   typedef struct packed {
      logic [REG_BITS-1:0]  reg_value;
      logic                 updated;
      logic [WORD_BITS-1:0] word_out;
      logic                 error;
   } rsp_type;

   typedef struct packed {
      func_type             func;
      logic [ADDR_BITS-1:0] addr;
      logic [SEL_BITS-1:0]  sel;
      logic [REG_BITS-1:0]  value;
      logic [WORD_BITS-1:0] word_data;
      logic                 error;
   } dec_type;

   typedef struct packed {
      logic                 en;
      logic [ADDR_BITS-1:0] addr;
      logic [WORD_BITS-1:0] data;
   } store_wr_type;

endpackage

// ===== design/pmrf_decode.sv =====
// Request decode: word address, field select and range check.
// Depends on pmrf_pkg.
module pmrf_decode (
   input  pmrf_pkg::req_type req,
   output pmrf_pkg::dec_type dec
);
   import pmrf_pkg::*;

   logic [PROD_BITS-1:0] prod;
   logic [ADDR_BITS-1:0] pos_word;
   logic [POS_BITS-1:0]  pos_rem;
   logic                 pos_ok;
   logic                 widx_ok;

   assign prod     = PROD_BITS'(req.position) * PROD_BITS'(DIV6_MULT);
   assign pos_word = prod[DIV6_SHIFT +: ADDR_BITS];
   assign pos_rem  = req.position - POS_BITS'(pos_word * REGS_PER_WORD);
   assign pos_ok   = 17'(req.position) < 17'(NUM_REGISTERS);
   assign widx_ok  = 9'(req.word_index) < 9'(NUM_WORDS);

   always_comb begin
      dec.func      = func_type'(req.func);
      dec.value     = req.value;
      dec.word_data = req.word_data;
      dec.sel       = pos_rem[SEL_BITS-1:0];
      dec.addr      = '0;
      dec.error     = 1'b0;
      case (req.func) inside
         FUNC_READ_REG, FUNC_WRITE_REG, FUNC_UPDATE_MAX: begin
            dec.error = !pos_ok;
            dec.addr  = pos_ok ? pos_word : '0;
         end
         FUNC_MERGE_WORD, FUNC_WRITE_WORD, FUNC_READ_WORD: begin
            dec.error = !widx_ok;
            dec.addr  = widx_ok ? ADDR_BITS'(req.word_index) : '0;
         end
         default: begin
            dec.error = 1'b0;
            dec.addr  = '0;
         end
      endcase
   end

endmodule

// ===== design/pmrf_word_store.sv =====
// Packed word memory with per-word valid bits and last-write forwarding.
// Depends on pmrf_pkg.
module pmrf_word_store (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              rd_en,
   input  logic [pmrf_pkg::ADDR_BITS-1:0]    rd_addr,
   output logic [pmrf_pkg::WORD_BITS-1:0]    rd_word,
   input  pmrf_pkg::store_wr_type            wr
);
   import pmrf_pkg::*;

   logic [WORD_BITS-1:0] words_ff [NUM_WORDS];
   logic [NUM_WORDS-1:0] valid_ff;
   logic [WORD_BITS-1:0] q_ff;
   logic                 q_valid_ff;
   logic [ADDR_BITS-1:0] rd_addr_ff;
   store_wr_type         last_wr_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         words_ff[wr.addr] <= wr.data;
      end
      if (rd_en) begin
         q_ff       <= words_ff[rd_addr];
         rd_addr_ff <= rd_addr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= '0;
         q_valid_ff    <= 1'b0;
         last_wr_ff.en <= 1'b0;
      end else begin
         if (wr.en) begin
            valid_ff[wr.addr] <= 1'b1;
            last_wr_ff        <= wr;
         end
         if (rd_en) begin
            q_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   always_comb begin
      if (last_wr_ff.en && last_wr_ff.addr == rd_addr_ff) begin
         rd_word = last_wr_ff.data;
      end else if (q_valid_ff) begin
         rd_word = q_ff;
      end else begin
         rd_word = '0;
      end
   end

endmodule

// ===== design/pmrf_modify.sv =====
// Read-modify-write datapath: field select, update-if-greater and merge.
// Depends on pmrf_pkg.
module pmrf_modify (
   input  pmrf_pkg::dec_type                dec,
   input  logic [pmrf_pkg::WORD_BITS-1:0]   cur_word,
   output logic                             wr_en,
   output logic [pmrf_pkg::WORD_BITS-1:0]   new_word,
   output pmrf_pkg::rsp_type                rsp
);
   import pmrf_pkg::*;

   logic [REGS_PER_WORD-1:0][REG_BITS-1:0] cur_f;
   logic [REGS_PER_WORD-1:0][REG_BITS-1:0] data_f;
   logic [REGS_PER_WORD-1:0][REG_BITS-1:0] set_f;
   logic [REGS_PER_WORD-1:0][REG_BITS-1:0] max_f;
   logic [REG_BITS-1:0]                    field;

   assign cur_f  = cur_word;
   assign data_f = dec.word_data;
   assign field  = cur_f[dec.sel];

   always_comb begin
      set_f          = cur_f;
      set_f[dec.sel] = dec.value;
      for (int j = 0; j < REGS_PER_WORD; j++) begin
         max_f[j] = (cur_f[j] < data_f[j]) ? data_f[j] : cur_f[j];
      end
   end

   always_comb begin
      wr_en    = 1'b0;
      new_word = cur_word;
      rsp      = '0;
      if (dec.error) begin
         rsp.error = 1'b1;
      end else begin
         case (dec.func)
            FUNC_READ_REG: begin
               rsp.reg_value = field;
               rsp.word_out  = cur_word;
            end
            FUNC_WRITE_REG: begin
               wr_en         = 1'b1;
               new_word      = set_f;
               rsp.reg_value = dec.value;
               rsp.word_out  = set_f;
            end
            FUNC_UPDATE_MAX: begin
               if (field < dec.value) begin
                  wr_en         = 1'b1;
                  new_word      = set_f;
                  rsp.updated   = 1'b1;
                  rsp.reg_value = dec.value;
                  rsp.word_out  = set_f;
               end else begin
                  rsp.reg_value = field;
                  rsp.word_out  = cur_word;
               end
            end
            FUNC_MERGE_WORD: begin
               wr_en        = 1'b1;
               new_word     = max_f;
               rsp.word_out = max_f;
            end
            FUNC_WRITE_WORD: begin
               wr_en        = 1'b1;
               new_word     = dec.word_data;
               rsp.word_out = dec.word_data;
            end
            FUNC_READ_WORD: begin
               rsp.word_out = cur_word;
            end
            default: begin
               rsp = '0;
            end
         endcase
      end
   end

endmodule

// ===== design/packed_max_register_file_top.sv =====
// Pipeline: the word memory is read and the request registered into stage s1 at acceptance;
// modify and the response register follow when s1 advances, which rsp_ready low can hold off.
// Throughput: one transaction per cycle while rsp_ready is high; the word memory is
// written back as the transaction leaves the modify stage, with the last write forwarded.
// req_ready falls only while both stages are full and rsp_ready is low.
// Reset: synchronous; clears pipeline control and all 171 word valid bits at once.
module packed_max_register_file_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  pmrf_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output pmrf_pkg::rsp_type rsp_data
);
   import pmrf_pkg::*;
   `include "packed_max_register_file_top_defines.svh"

   dec_type              dec_in;
   dec_type              s1_ff;
   logic                 s1_valid_ff;
   logic                 s1_valid_in;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   rsp_type              rsp_ff;
   rsp_type              rsp_in;
   logic                 accept;
   logic                 advance;
   logic [WORD_BITS-1:0] cur_word;
   logic [WORD_BITS-1:0] new_word;
   logic                 mod_wr_en;
   store_wr_type         wr;

   pmrf_decode u_decode (
      .req (req_data),
      .dec (dec_in)
   );

   pmrf_word_store u_store (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .rd_addr (dec_in.addr),
      .rd_word (cur_word),
      .wr      (wr)
   );

   pmrf_modify u_modify (
      .dec      (s1_ff),
      .cur_word (cur_word),
      .wr_en    (mod_wr_en),
      .new_word (new_word),
      .rsp      (rsp_in)
   );

   assign advance   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;
   assign accept    = req_valid && req_ready;

   assign wr.en   = advance && mod_wr_en;
   assign wr.addr = s1_ff.addr;
   assign wr.data = new_word;

   assign s1_valid_in  = accept || (s1_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= dec_in;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `PMRF_ASSERT_NEXT(a_stage_drains, clock, reset, advance, rsp_valid_ff, "advanced transaction missing at output")
   `PMRF_ASSERT(a_ready_stall, clock, reset, !req_ready |-> (s1_valid_ff && rsp_valid_ff && !rsp_ready), "request stalled without full pipeline")
   `PMRF_ASSERT(a_error_zero, clock, reset, (rsp_valid_ff && rsp_ff.error) |-> (rsp_ff.word_out == '0 && rsp_ff.reg_value == '0 && !rsp_ff.updated), "error response carries payload")
   `PMRF_ASSERT(a_no_err_write, clock, reset, wr.en |-> (s1_valid_ff && !s1_ff.error), "store written by an erroneous transaction")
   `PMRF_ASSERT(a_updated_nonzero, clock, reset, (rsp_valid_ff && rsp_ff.updated) |-> (rsp_ff.reg_value != '0), "raised register reads zero")

endmodule
